@@ src/pwag_pkg.sv @@
package pwag_pkg;

    localparam int TABLE_SIZE = 8192;
    localparam int TABLE_AW   = $clog2(TABLE_SIZE);
    localparam int MAX_SIDE   = 4096;

    localparam int CMD_W    = 2;
    localparam int SIDE_W   = 13;
    localparam int COORD_W  = 12;
    localparam int FIELD_W  = 13;
    localparam int VALUE_W  = 18;
    localparam int INDEX_W  = 24;
    localparam int BLOOM_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam int ENTRY_W  = 17;
    localparam int GAIN_W   = 17;
    localparam int P1_W     = 18;
    localparam int P2_W     = 19;
    localparam int DIFF_W   = COORD_W + 1;

    localparam int Q_SHIFT  = 16;
    localparam int Q_HALF   = 32768;
    localparam int BLOOM_ROUND = 500;

    // floor(m / 125) == (m * GAIN_RECIP) >> GAIN_RSHIFT for m < 2**24
    localparam logic [24:0] GAIN_RECIP  = 25'd17179870;
    localparam int          GAIN_RSHIFT = 31;

    localparam int COS_MIN = -65536;
    localparam int COS_MAX = 65535;

    localparam logic [SIDE_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [SIDE_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [BLOOM_W-1:0] BLOOM_RESET  = 10'd500;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL      = 2'd0,
        CMD_LOAD_COS   = 2'd1,
        CMD_LOAD_DECAY = 2'd2
    } pwag_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLOOM_AMOUNT = 2'd2,
        REG_PHASE_INDEX  = 2'd3
    } pwag_reg_t;

    typedef struct packed {
        logic [SIDE_W-1:0]   width;
        logic [SIDE_W-1:0]   height;
        logic [COORD_W-1:0]  centre_x;
        logic [COORD_W-1:0]  centre_y;
        logic [TABLE_AW-1:0] phase;
        logic [GAIN_W-1:0]   gain;
    } pwag_cfg_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] cosine;
        logic [ENTRY_W-1:0]        decay;
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
    } pwag_tap_t;

    typedef struct packed {
        logic signed [P2_W-1:0]   p;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
    } pwag_disp_t;

endpackage

@@ src/pwag_cfg.sv @@
module pwag_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwag_pkg::SIDE_W-1:0]       cfg_data,
    output pwag_pkg::pwag_cfg_t               cfg_o
);

    logic [pwag_pkg::SIDE_W-1:0]   width_reg;
    logic [pwag_pkg::SIDE_W-1:0]   height_reg;
    logic [pwag_pkg::BLOOM_W-1:0]  bloom_reg;
    logic [pwag_pkg::TABLE_AW-1:0] phase_reg;

    logic [pwag_pkg::SIDE_W-1:0]   width_eff_reg,  width_eff_next;
    logic [pwag_pkg::SIDE_W-1:0]   height_eff_reg, height_eff_next;
    logic [pwag_pkg::COORD_W-1:0]  centre_x_reg;
    logic [pwag_pkg::COORD_W-1:0]  centre_y_reg;
    logic [25:0]                   bloom_num;
    logic [47:0]                   gain_prod_reg, gain_prod_next;
    logic [pwag_pkg::GAIN_W-1:0]   gain_reg, gain_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pwag_pkg::WIDTH_RESET;
            height_reg <= pwag_pkg::HEIGHT_RESET;
            bloom_reg  <= pwag_pkg::BLOOM_RESET;
            phase_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (pwag_pkg::pwag_reg_t'(cfg_index))
                pwag_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                pwag_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                pwag_pkg::REG_BLOOM_AMOUNT: bloom_reg  <= cfg_data[pwag_pkg::BLOOM_W-1:0];
                pwag_pkg::REG_PHASE_INDEX:  phase_reg  <= cfg_data[pwag_pkg::TABLE_AW-1:0];
            endcase
        end
    end

    // zero acts as one, oversize clamps to the largest side
    always_comb begin
        if (width_reg == '0)
            width_eff_next = pwag_pkg::SIDE_W'(1);
        else if (32'(width_reg) > pwag_pkg::MAX_SIDE)
            width_eff_next = pwag_pkg::SIDE_W'(pwag_pkg::MAX_SIDE);
        else
            width_eff_next = width_reg;

        if (height_reg == '0)
            height_eff_next = pwag_pkg::SIDE_W'(1);
        else if (32'(height_reg) > pwag_pkg::MAX_SIDE)
            height_eff_next = pwag_pkg::SIDE_W'(pwag_pkg::MAX_SIDE);
        else
            height_eff_next = height_reg;
    end

    // gain = 32768 + (bloom * 65536 + 500) / 1000, divide as /8 then reciprocal of 125
    assign bloom_num      = {bloom_reg, 16'b0} + 26'(pwag_pkg::BLOOM_ROUND);
    assign gain_prod_next = 48'(bloom_num[25:3]) * 48'(pwag_pkg::GAIN_RECIP);
    assign gain_next      = pwag_pkg::GAIN_W'(pwag_pkg::Q_HALF)
                          + pwag_pkg::GAIN_W'(gain_prod_reg >> pwag_pkg::GAIN_RSHIFT);

    always_ff @(posedge aclk) begin
        width_eff_reg  <= width_eff_next;
        height_eff_reg <= height_eff_next;
        centre_x_reg   <= pwag_pkg::COORD_W'(width_eff_next >> 1);
        centre_y_reg   <= pwag_pkg::COORD_W'(height_eff_next >> 1);
        gain_prod_reg  <= gain_prod_next;
        gain_reg       <= gain_next;
    end

    assign cfg_o.width    = width_eff_reg;
    assign cfg_o.height   = height_eff_reg;
    assign cfg_o.centre_x = centre_x_reg;
    assign cfg_o.centre_y = centre_y_reg;
    assign cfg_o.phase    = phase_reg;
    assign cfg_o.gain     = gain_reg;

endmodule

@@ src/pwag_lookup.sv @@
module pwag_lookup (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pwag_pkg::pwag_cfg_t               cfg_i,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pwag_pkg::CMD_W-1:0]        s_command,
    input  logic [pwag_pkg::COORD_W-1:0]      s_pixel_x,
    input  logic [pwag_pkg::COORD_W-1:0]      s_pixel_y,
    input  logic [pwag_pkg::FIELD_W-1:0]      s_angle_index,
    input  logic [pwag_pkg::FIELD_W-1:0]      s_distance_index,
    input  logic [pwag_pkg::FIELD_W-1:0]      s_table_address,
    input  logic signed [pwag_pkg::VALUE_W-1:0] s_table_value,
    output logic                              tap_valid,
    input  logic                              tap_ready,
    output pwag_pkg::pwag_tap_t               tap_o
);

    logic [pwag_pkg::ENTRY_W-1:0] cos_mem [pwag_pkg::TABLE_SIZE];
    logic [pwag_pkg::ENTRY_W-1:0] decay_mem [pwag_pkg::TABLE_SIZE];

    logic                           accept;
    logic                           pixel_rd;
    logic                           addr_ok;
    logic                           load_cos;
    logic                           load_decay;
    logic [pwag_pkg::TABLE_AW-1:0]  wr_addr;
    logic [pwag_pkg::TABLE_AW-1:0]  angle_addr;
    logic [pwag_pkg::TABLE_AW-1:0]  dist_addr;
    logic [pwag_pkg::ENTRY_W-1:0]   cos_val;
    logic [pwag_pkg::ENTRY_W-1:0]   decay_val;

    logic                           valid_reg;
    logic [pwag_pkg::ENTRY_W-1:0]   cos_rd_reg;
    logic [pwag_pkg::ENTRY_W-1:0]   decay_rd_reg;
    logic [pwag_pkg::COORD_W-1:0]   x_reg;
    logic [pwag_pkg::COORD_W-1:0]   y_reg;

    assign s_ready = !valid_reg || tap_ready;
    assign accept  = s_valid && s_ready;

    assign addr_ok    = 32'(s_table_address) < pwag_pkg::TABLE_SIZE;
    assign wr_addr    = s_table_address[pwag_pkg::TABLE_AW-1:0];
    assign load_cos   = accept && addr_ok && (s_command == pwag_pkg::CMD_LOAD_COS);
    assign load_decay = accept && addr_ok && (s_command == pwag_pkg::CMD_LOAD_DECAY);
    assign pixel_rd   = accept && (s_command == pwag_pkg::CMD_PIXEL);

    // angle wraps around the table
    assign angle_addr = pwag_pkg::TABLE_AW'(32'(s_angle_index) + 32'(cfg_i.phase));
    assign dist_addr  = (32'(s_distance_index) >= pwag_pkg::TABLE_SIZE)
                      ? pwag_pkg::TABLE_AW'(pwag_pkg::TABLE_SIZE - 1)
                      : s_distance_index[pwag_pkg::TABLE_AW-1:0];

    always_comb begin
        if (int'(s_table_value) < pwag_pkg::COS_MIN)
            cos_val = pwag_pkg::ENTRY_W'(pwag_pkg::COS_MIN);
        else if (int'(s_table_value) > pwag_pkg::COS_MAX)
            cos_val = pwag_pkg::ENTRY_W'(pwag_pkg::COS_MAX);
        else
            cos_val = s_table_value[pwag_pkg::ENTRY_W-1:0];

        if (s_table_value < 0)
            decay_val = '0;
        else
            decay_val = s_table_value[pwag_pkg::ENTRY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load_cos)
            cos_mem[wr_addr] <= cos_val;
        if (pixel_rd)
            cos_rd_reg <= cos_mem[angle_addr];
    end

    always_ff @(posedge aclk) begin
        if (load_decay)
            decay_mem[wr_addr] <= decay_val;
        if (pixel_rd)
            decay_rd_reg <= decay_mem[dist_addr];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_pixel_x;
            y_reg <= s_pixel_y;
        end
    end

    // loads and unknown commands leave a bubble
    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else if (s_ready)
            valid_reg <= accept && (s_command == pwag_pkg::CMD_PIXEL);
    end

    assign tap_valid    = valid_reg;
    assign tap_o.cosine = $signed(cos_rd_reg);
    assign tap_o.decay  = decay_rd_reg;
    assign tap_o.x      = x_reg;
    assign tap_o.y      = y_reg;

endmodule

@@ src/pwag_scale.sv @@
module pwag_scale (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pwag_pkg::pwag_cfg_t   cfg_i,
    input  logic                  tap_valid,
    output logic                  tap_ready,
    input  pwag_pkg::pwag_tap_t   tap_i,
    output logic                  disp_valid,
    input  logic                  disp_ready,
    output pwag_pkg::pwag_disp_t  disp_o
);

    logic                                  en2;
    logic                                  en3;
    logic signed [34:0]                    prod1_next;
    logic signed [35:0]                    prod2_next;
    logic signed [pwag_pkg::DIFF_W-1:0]    dx_next;
    logic signed [pwag_pkg::DIFF_W-1:0]    dy_next;

    logic                                  v2_reg;
    logic signed [pwag_pkg::P1_W-1:0]      p1_reg;
    logic [pwag_pkg::COORD_W-1:0]          x2_reg;
    logic [pwag_pkg::COORD_W-1:0]          y2_reg;

    logic                                  v3_reg;
    logic signed [pwag_pkg::P2_W-1:0]      p2_reg;
    logic signed [pwag_pkg::DIFF_W-1:0]    dx3_reg;
    logic signed [pwag_pkg::DIFF_W-1:0]    dy3_reg;
    logic [pwag_pkg::COORD_W-1:0]          x3_reg;
    logic [pwag_pkg::COORD_W-1:0]          y3_reg;

    assign en3       = !v3_reg || disp_ready;
    assign en2       = !v2_reg || en3;
    assign tap_ready = en2;

    // cosine times decay, floor of Q16
    assign prod1_next = 35'($signed(tap_i.cosine)) * 35'($signed({1'b0, tap_i.decay}));

    always_ff @(posedge aclk) begin
        if (en2 && tap_valid) begin
            p1_reg <= prod1_next[pwag_pkg::Q_SHIFT+pwag_pkg::P1_W-1:pwag_pkg::Q_SHIFT];
            x2_reg <= tap_i.x;
            y2_reg <= tap_i.y;
        end
    end

    // bloom gain with rounding, then offsets from the centre
    assign prod2_next = 36'(p1_reg) * 36'($signed({1'b0, cfg_i.gain}))
                      + 36'(pwag_pkg::Q_HALF);
    assign dx_next = pwag_pkg::DIFF_W'({1'b0, x2_reg}) - pwag_pkg::DIFF_W'({1'b0, cfg_i.centre_x});
    assign dy_next = pwag_pkg::DIFF_W'({1'b0, y2_reg}) - pwag_pkg::DIFF_W'({1'b0, cfg_i.centre_y});

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            p2_reg  <= prod2_next[pwag_pkg::Q_SHIFT+pwag_pkg::P2_W-1:pwag_pkg::Q_SHIFT];
            dx3_reg <= dx_next;
            dy3_reg <= dy_next;
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en2)
                v2_reg <= tap_valid;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    assign disp_valid = v3_reg;
    assign disp_o.p   = p2_reg;
    assign disp_o.dx  = dx3_reg;
    assign disp_o.dy  = dy3_reg;
    assign disp_o.x   = x3_reg;
    assign disp_o.y   = y3_reg;

endmodule

@@ src/pwag_map.sv @@
module pwag_map (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pwag_pkg::pwag_cfg_t            cfg_i,
    input  logic                           disp_valid,
    output logic                           disp_ready,
    input  pwag_pkg::pwag_disp_t           disp_i,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pwag_pkg::COORD_W-1:0]   m_source_x,
    output logic [pwag_pkg::COORD_W-1:0]   m_source_y,
    output logic [pwag_pkg::INDEX_W-1:0]   m_source_index
);

    logic                                en4;
    logic                                en5;
    logic                                en6;

    logic                                v4_reg;
    logic signed [31:0]                  offx_prod_reg;
    logic signed [31:0]                  offy_prod_reg;
    logic [pwag_pkg::COORD_W-1:0]        x4_reg;
    logic [pwag_pkg::COORD_W-1:0]        y4_reg;

    logic signed [16:0]                  mx_next;
    logic signed [16:0]                  my_next;
    logic [pwag_pkg::SIDE_W-1:0]         x_max;
    logic [pwag_pkg::SIDE_W-1:0]         y_max;
    logic [pwag_pkg::COORD_W-1:0]        sx_next;
    logic [pwag_pkg::COORD_W-1:0]        sy_next;

    logic                                v5_reg;
    logic [pwag_pkg::COORD_W-1:0]        sx5_reg;
    logic [pwag_pkg::COORD_W-1:0]        sy5_reg;

    logic [24:0]                         index_next;
    logic                                v6_reg;
    logic [pwag_pkg::COORD_W-1:0]        sx6_reg;
    logic [pwag_pkg::COORD_W-1:0]        sy6_reg;
    logic [pwag_pkg::INDEX_W-1:0]        index_reg;

    assign en6        = !v6_reg || m_ready;
    assign en5        = !v5_reg || en6;
    assign en4        = !v4_reg || en5;
    assign disp_ready = en4;

    always_ff @(posedge aclk) begin
        if (en4 && disp_valid) begin
            offx_prod_reg <= 32'(disp_i.dx) * 32'(disp_i.p);
            offy_prod_reg <= 32'(disp_i.dy) * 32'(disp_i.p);
            x4_reg        <= disp_i.x;
            y4_reg        <= disp_i.y;
        end
    end

    // displace, then clamp into the frame
    assign mx_next = 17'($signed({1'b0, x4_reg}))
                   + 17'($signed(offx_prod_reg[31:pwag_pkg::Q_SHIFT]));
    assign my_next = 17'($signed({1'b0, y4_reg}))
                   + 17'($signed(offy_prod_reg[31:pwag_pkg::Q_SHIFT]));
    assign x_max   = cfg_i.width - pwag_pkg::SIDE_W'(1);
    assign y_max   = cfg_i.height - pwag_pkg::SIDE_W'(1);

    always_comb begin
        if (mx_next < 0)
            sx_next = '0;
        else if (mx_next > $signed({4'b0, x_max}))
            sx_next = x_max[pwag_pkg::COORD_W-1:0];
        else
            sx_next = mx_next[pwag_pkg::COORD_W-1:0];

        if (my_next < 0)
            sy_next = '0;
        else if (my_next > $signed({4'b0, y_max}))
            sy_next = y_max[pwag_pkg::COORD_W-1:0];
        else
            sy_next = my_next[pwag_pkg::COORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en5 && v4_reg) begin
            sx5_reg <= sx_next;
            sy5_reg <= sy_next;
        end
    end

    assign index_next = 25'(sy5_reg) * 25'(cfg_i.width) + 25'(sx5_reg);

    always_ff @(posedge aclk) begin
        if (en6 && v5_reg) begin
            sx6_reg   <= sx5_reg;
            sy6_reg   <= sy5_reg;
            index_reg <= index_next[pwag_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en4)
                v4_reg <= disp_valid;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                v6_reg <= v5_reg;
        end
    end

    assign m_valid        = v6_reg;
    assign m_source_x     = sx6_reg;
    assign m_source_y     = sy6_reg;
    assign m_source_index = index_reg;

endmodule

@@ src/petal_warp_address_generator_top.sv @@
// Petal warp address generator: takes one transaction per clock while s_ready is high and
// returns one source address for each accepted pixel; load and unknown commands return
// nothing. Six register stages lie between a pixel and its address: table read,
// cosine-times-decay multiply, gain multiply, offset multiply, displace and clamp, and the
// linear index multiply. Each table has one port used once per cycle, a load writing it in
// the same cycle an item is accepted, so a pixel right after a load sees the new entry.
// Reading a table entry that was never loaded gives an undefined result. A change of
// bloom_amount reaches the gain through gain_prod_reg and gain_reg, frame size through the
// effective-size registers, and a new phase applies to the very next transaction.
module petal_warp_address_generator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pwag_pkg::SIDE_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pwag_pkg::CMD_W-1:0]          s_command,
    input  logic [pwag_pkg::COORD_W-1:0]        s_pixel_x,
    input  logic [pwag_pkg::COORD_W-1:0]        s_pixel_y,
    input  logic [pwag_pkg::FIELD_W-1:0]        s_angle_index,
    input  logic [pwag_pkg::FIELD_W-1:0]        s_distance_index,
    input  logic [pwag_pkg::FIELD_W-1:0]        s_table_address,
    input  logic signed [pwag_pkg::VALUE_W-1:0] s_table_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pwag_pkg::COORD_W-1:0]        m_source_x,
    output logic [pwag_pkg::COORD_W-1:0]        m_source_y,
    output logic [pwag_pkg::INDEX_W-1:0]        m_source_index
);

    pwag_pkg::pwag_cfg_t  cfg;
    pwag_pkg::pwag_tap_t  tap;
    pwag_pkg::pwag_disp_t disp;
    logic                 tap_valid;
    logic                 tap_ready;
    logic                 disp_valid;
    logic                 disp_ready;

    pwag_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg)
    );

    pwag_lookup u_lookup (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_i            (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pixel_x        (s_pixel_x),
        .s_pixel_y        (s_pixel_y),
        .s_angle_index    (s_angle_index),
        .s_distance_index (s_distance_index),
        .s_table_address  (s_table_address),
        .s_table_value    (s_table_value),
        .tap_valid        (tap_valid),
        .tap_ready        (tap_ready),
        .tap_o            (tap)
    );

    pwag_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg),
        .tap_valid  (tap_valid),
        .tap_ready  (tap_ready),
        .tap_i      (tap),
        .disp_valid (disp_valid),
        .disp_ready (disp_ready),
        .disp_o     (disp)
    );

    pwag_map u_map (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_i          (cfg),
        .disp_valid     (disp_valid),
        .disp_ready     (disp_ready),
        .disp_i         (disp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_source_x     (m_source_x),
        .m_source_y     (m_source_y),
        .m_source_index (m_source_index)
    );

endmodule

@@ src/pwag_checker.sv @@
module pwag_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [pwag_pkg::COORD_W-1:0]      m_source_x,
    input logic [pwag_pkg::COORD_W-1:0]      m_source_y,
    input logic [pwag_pkg::INDEX_W-1:0]      m_source_index
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_source_x) && $stable(m_source_y)
                                && $stable(m_source_index))
        else $error("result changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a draining output never throttles the input
    assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind petal_warp_address_generator_top pwag_checker u_pwag_checker (.*);

@@ dv/petal_warp_address_checker.sv @@
`timescale 1ns / 100ps

module petal_warp_address_checker
    import pwag_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SIDE_W-1:0]          cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [CMD_W-1:0]           s_command,
    input  logic [COORD_W-1:0]         s_pixel_x,
    input  logic [COORD_W-1:0]         s_pixel_y,
    input  logic [FIELD_W-1:0]         s_angle_index,
    input  logic [FIELD_W-1:0]         s_distance_index,
    input  logic [FIELD_W-1:0]         s_table_address,
    input  logic signed [VALUE_W-1:0]  s_table_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [COORD_W-1:0]         m_source_x,
    input  logic [COORD_W-1:0]         m_source_y,
    input  logic [INDEX_W-1:0]         m_source_index,
    output int                         mismatch_count,
    output int                         pending_count
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] index;
    } source_addr_t;

    logic signed [ENTRY_W-1:0] cos_mem   [TABLE_SIZE];
    logic [ENTRY_W-1:0]        decay_mem [TABLE_SIZE];

    logic [SIDE_W-1:0]   width_reg;
    logic [SIDE_W-1:0]   height_reg;
    logic [BLOOM_W-1:0]  bloom_reg;
    logic [TABLE_AW-1:0] phase_reg;

    source_addr_t expected_addr_q [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] source address check: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint usable_side(input logic [SIDE_W-1:0] s);
        if (s == 0) return 1;
        if (s > MAX_SIDE) return MAX_SIDE;
        return longint'(s);
    endfunction

    function automatic source_addr_t predict_source(input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] py,
                                                    input logic [FIELD_W-1:0] ang,
                                                    input logic [FIELD_W-1:0] dist_idx);
        longint w, h, xl, yl, gain, disp, mx, my, sx, sy;
        logic [TABLE_AW-1:0] rot;
        source_addr_t r;
        w    = usable_side(width_reg);
        h    = usable_side(height_reg);
        xl   = longint'(px);
        yl   = longint'(py);
        rot  = ang + phase_reg;
        gain = 32768 + (longint'(bloom_reg) * 65536 + 500) / 1000;
        // every shift below rounds toward minus infinity
        disp = (longint'(cos_mem[rot]) * longint'(decay_mem[dist_idx])) >>> Q_SHIFT;
        disp = (disp * gain + Q_HALF) >>> Q_SHIFT;
        mx   = xl + (((xl - (w >>> 1)) * disp) >>> Q_SHIFT);
        my   = yl + (((yl - (h >>> 1)) * disp) >>> Q_SHIFT);
        sx   = clamp_to(mx, 0, w - 1);
        sy   = clamp_to(my, 0, h - 1);
        r.x     = COORD_W'(sx);
        r.y     = COORD_W'(sy);
        r.index = INDEX_W'(sy * w + sx);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        source_addr_t want;
        longint       val;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            bloom_reg  = BLOOM_RESET;
            phase_reg  = '0;
            expected_addr_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (pwag_reg_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_reg  = cfg_data;
                    REG_FRAME_HEIGHT: height_reg = cfg_data;
                    REG_BLOOM_AMOUNT: bloom_reg  = cfg_data[BLOOM_W-1:0];
                    REG_PHASE_INDEX:  phase_reg  = cfg_data[TABLE_AW-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_addr_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no transaction pending",
                                              m_source_x, m_source_y, m_source_index));
                end else begin
                    want = expected_addr_q.pop_front();
                    if (m_source_x !== want.x)
                        report_mismatch($sformatf("source_x %0d, want %0d", m_source_x, want.x));
                    if (m_source_y !== want.y)
                        report_mismatch($sformatf("source_y %0d, want %0d", m_source_y, want.y));
                    if (m_source_index !== want.index)
                        report_mismatch($sformatf("source_index %0d, want %0d",
                                                  m_source_index, want.index));
                end
            end

            if (s_valid && s_ready) begin
                val = longint'(s_table_value);
                case (s_command)
                    CMD_PIXEL:
                        expected_addr_q.push_back(predict_source(s_pixel_x, s_pixel_y,
                                                                 s_angle_index,
                                                                 s_distance_index));
                    CMD_LOAD_COS:
                        cos_mem[s_table_address] = ENTRY_W'(clamp_to(val, COS_MIN, COS_MAX));
                    CMD_LOAD_DECAY:
                        decay_mem[s_table_address] = ENTRY_W'(clamp_to(val, 0, 131071));
                    default: ;  // drop unknown commands
                endcase
            end
        end
        pending_count = expected_addr_q.size();
    end

endmodule

@@ dv/petal_warp_address_generator_top_tb.sv @@
`timescale 1ns / 100ps

module petal_warp_address_generator_top_tb;
    import pwag_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [SIDE_W-1:0]         cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [CMD_W-1:0]          s_command;
    logic [COORD_W-1:0]        s_pixel_x;
    logic [COORD_W-1:0]        s_pixel_y;
    logic [FIELD_W-1:0]        s_angle_index;
    logic [FIELD_W-1:0]        s_distance_index;
    logic [FIELD_W-1:0]        s_table_address;
    logic signed [VALUE_W-1:0] s_table_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [COORD_W-1:0]        m_source_x;
    logic [COORD_W-1:0]        m_source_y;
    logic [INDEX_W-1:0]        m_source_index;

    int mismatches;
    int pending;
    int cycle_count;
    int hold_requests;
    int holds_done;
    int send_gap_pct;
    int recv_gap_pct;
    bit quiet;

    // stimulus side bookkeeping: only loaded entries may be read
    logic [TABLE_AW-1:0] cur_phase;
    logic [TABLE_AW-1:0] cos_loaded   [$];
    logic [TABLE_AW-1:0] decay_loaded [$];
    bit                  cos_seen     [TABLE_SIZE];
    bit                  decay_seen   [TABLE_SIZE];

    petal_warp_address_generator_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pixel_x        (s_pixel_x),
        .s_pixel_y        (s_pixel_y),
        .s_angle_index    (s_angle_index),
        .s_distance_index (s_distance_index),
        .s_table_address  (s_table_address),
        .s_table_value    (s_table_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_x       (m_source_x),
        .m_source_y       (m_source_y),
        .m_source_index   (m_source_index)
    );

    petal_warp_address_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pixel_x        (s_pixel_x),
        .s_pixel_y        (s_pixel_y),
        .s_angle_index    (s_angle_index),
        .s_distance_index (s_distance_index),
        .s_table_address  (s_table_address),
        .s_table_value    (s_table_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_x       (m_source_x),
        .m_source_y       (m_source_y),
        .m_source_index   (m_source_index),
        .mismatch_count   (mismatches),
        .pending_count    (pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("petal_warp_address_generator_top: mismatch");
            $finish;
        end
    end

    // result side: random stall bursts, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_requests) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                holds_done++;
                m_ready = 1'b1;
            end else if (!quiet && $urandom_range(1, 100) <= recv_gap_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0]          cmd,
                             input logic [COORD_W-1:0]        x,
                             input logic [COORD_W-1:0]        y,
                             input logic [FIELD_W-1:0]        ang,
                             input logic [FIELD_W-1:0]        dist_idx,
                             input logic [FIELD_W-1:0]        addr,
                             input logic signed [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(1, 100) <= send_gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_command        = cmd;
        s_pixel_x        = x;
        s_pixel_y        = y;
        s_angle_index    = ang;
        s_distance_index = dist_idx;
        s_table_address  = addr;
        s_table_value    = value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [CMD_W-1:0]          cmd,
                              input logic [TABLE_AW-1:0]       addr,
                              input logic signed [VALUE_W-1:0] value);
        if (cmd == CMD_LOAD_COS && !cos_seen[addr]) begin
            cos_seen[addr] = 1'b1;
            cos_loaded.push_back(addr);
        end
        if (cmd == CMD_LOAD_DECAY && !decay_seen[addr]) begin
            decay_seen[addr] = 1'b1;
            decay_loaded.push_back(addr);
        end
        send_item(cmd, COORD_W'($urandom), COORD_W'($urandom), FIELD_W'($urandom),
                  FIELD_W'($urandom), addr, value);
    endtask

    // aim the rotated angle at a loaded cosine entry
    task automatic send_pixel(input logic [COORD_W-1:0]  x,
                              input logic [COORD_W-1:0]  y,
                              input logic [TABLE_AW-1:0] cos_addr,
                              input logic [TABLE_AW-1:0] decay_addr);
        logic [TABLE_AW-1:0] ang;
        ang = cos_addr - cur_phase;
        send_item(CMD_PIXEL, x, y, ang, decay_addr, FIELD_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic send_random_item();
        int pick;
        logic signed [VALUE_W-1:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            send_pixel(COORD_W'($urandom), COORD_W'($urandom),
                       cos_loaded[$urandom_range(0, cos_loaded.size() - 1)],
                       decay_loaded[$urandom_range(0, decay_loaded.size() - 1)]);
        end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0) value = VALUE_W'($urandom);
            else value = VALUE_W'(int'($urandom_range(0, 65536)) - 32768);
            load_entry(CMD_LOAD_COS, TABLE_AW'($urandom), value);
        end else if (pick < 96) begin
            if ($urandom_range(0, 3) == 0) value = VALUE_W'($urandom);
            else value = VALUE_W'($urandom_range(0, 65536));
            load_entry(CMD_LOAD_DECAY, TABLE_AW'($urandom), value);
        end else begin
            send_item(CMD_UNKNOWN, COORD_W'($urandom), COORD_W'($urandom), FIELD_W'($urandom),
                      FIELD_W'($urandom), FIELD_W'($urandom), VALUE_W'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input pwag_reg_t idx, input logic [SIDE_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                             input logic [SIDE_W-1:0] bloom, input logic [SIDE_W-1:0] ph);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BLOOM_AMOUNT, bloom);
        write_reg(REG_PHASE_INDEX, ph);
        cur_phase = ph[TABLE_AW-1:0];
        // let the gain settle
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_FRAME_WIDTH;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_command        = CMD_PIXEL;
        s_pixel_x        = '0;
        s_pixel_y        = '0;
        s_angle_index    = '0;
        s_distance_index = '0;
        s_table_address  = '0;
        s_table_value    = '0;
        cur_phase        = '0;
        quiet            = 1'b0;
        send_gap_pct     = 15;
        recv_gap_pct     = 15;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // table extremes, saturating loads, frame corners and centre
        load_entry(CMD_LOAD_COS, 0, 131071);
        load_entry(CMD_LOAD_COS, 8191, -131072);
        load_entry(CMD_LOAD_COS, 4096, -32768);
        load_entry(CMD_LOAD_DECAY, 0, -1);
        load_entry(CMD_LOAD_DECAY, 8191, 131071);
        load_entry(CMD_LOAD_DECAY, 2730, 65536);
        send_pixel(0, 0, 0, 8191);
        send_pixel(4095, 4095, 8191, 8191);
        send_pixel(320, 240, 0, 2730);
        send_pixel(4095, 0, 4096, 2730);
        send_pixel(0, 4095, 8191, 0);
        send_pixel(1, 479, 0, 8191);
        send_item(CMD_UNKNOWN, 4095, 4095, 8191, 8191, 8191, -1);
        // overwrite an entry and read it back on the next transaction
        load_entry(CMD_LOAD_COS, 4096, 65536);
        send_pixel(639, 0, 4096, 8191);
        send_pixel(2048, 2048, 4096, 2730);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_frame(1, 1, 0, 8191);
                1: set_frame(4096, 4096, 1000, 1);
                2: set_frame(0, 0, 1023, 4096);
                3: set_frame(8191, 4097, 1, 123);
                4: set_frame(SIDE_W'($urandom_range(1, 1024)), SIDE_W'($urandom_range(1, 1024)),
                             SIDE_W'($urandom), SIDE_W'($urandom));
                default: set_frame(SIDE_W'($urandom), SIDE_W'($urandom),
                                   SIDE_W'($urandom_range(0, 1023)), SIDE_W'($urandom));
            endcase
            case ($urandom_range(0, 2))
                0: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
                1: begin send_gap_pct = 10; recv_gap_pct = 25; end
                default: begin send_gap_pct = 30; recv_gap_pct = 10; end
            endcase
            if (ph == 2) hold_requests++;
            if (ph == PHASES - 1) quiet = 1'b1;
            repeat (PHASE_ITEMS) send_random_item();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("petal_warp_address_generator_top: match");
        end else begin
            $display("petal_warp_address_generator_top: mismatch");
        end
        $finish;
    end

endmodule
